>>> rtl/assert_macros.svh
// Assertion macros shared by the RTL files.
// Depends on nothing; included by files that assert.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a property holds on every clock edge outside reset.
`define CHK_PROP(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition implies something on the next clock edge.
`define CHK_NEXT(label, clk, rst_n, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error(msg);

`endif

>>> rtl/vdi_pkg.sv
// Shared constants, types and functions for the vertex dedup indexer.
// Depends on nothing.
`default_nettype none
package vdi_pkg;
    localparam int MaxVertices = 4096;
    localparam int TableSlots  = 8192;
    localparam int SlotBits    = $clog2(TableSlots);
    localparam int CountBits   = 13;
    localparam int IdxBits     = 12;
    localparam int ProbeBits   = SlotBits + 1;
    localparam logic [31:0] HashMix  = 32'h9e3779b9;
    localparam logic [31:0] MinReset = 32'h7F7FFFFF;
    localparam logic [31:0] MaxReset = 32'hFF7FFFFF;

    typedef struct packed {
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] z;
    } pos_t;

    typedef struct packed {
        logic [IdxBits-1:0] index;
        logic               is_new;
        logic               full;
        logic               fresh;
    } lookup_t;

    function automatic logic [31:0] hash_step(input logic [31:0] h, input logic [31:0] v);
        hash_step = h ^ (v + HashMix + (h << 6) + (h >> 2));
    endfunction

    function automatic logic is_nan(input logic [31:0] a);
        is_nan = (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
    endfunction

    function automatic logic flt_less(input logic [31:0] a, input logic [31:0] b);
        logic [31:0] ka;
        logic [31:0] kb;
        ka = a[31] ? ~a : (a | 32'h80000000);
        kb = b[31] ? ~b : (b | 32'h80000000);
        if (is_nan(a) || is_nan(b))
            flt_less = 1'b0;
        else if (a[30:0] == 31'd0 && b[30:0] == 31'd0)
            flt_less = 1'b0;
        else
            flt_less = ka < kb;
    endfunction
endpackage
`default_nettype wire

>>> rtl/vertex_dedup_indexer.sv
// Vertex dedup indexer top level: corner sequencing, bounds, result strobe.
// Depends on vdi_pkg, vdi_table, assert_macros.svh.
//
// Use: drive the nine corner coordinate ports and pulse start while busy is
// low; the triangle request is taken at that edge and the ports may change after.
// The block then welds corner 0, 1 and 2 in turn. Each corner produces one
// result, held on the result ports for exactly one cycle with valid high;
// the receiver cannot stall, so it must take each result when shown.
// last_of_triangle marks the third result.
// Per corner the steps are issue, two hash rounds, the home slot read, one
// check and one handoff, plus one more check per extra collision probe.
// Busy stays high through the last result cycle, so a new request is only
// taken after all three results of the previous one. The serial lookup of
// one corner at a time through the slot memory sets this.
// After reset the slot valid memory is cleared by a sweep over all 8192 slots,
// during which busy stays high; counters and bounds reset at once.
`default_nettype none
`include "assert_macros.svh"
module vertex_dedup_indexer
    import vdi_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [31:0] corner0_x,
    input  wire logic [31:0] corner0_y,
    input  wire logic [31:0] corner0_z,
    input  wire logic [31:0] corner1_x,
    input  wire logic [31:0] corner1_y,
    input  wire logic [31:0] corner1_z,
    input  wire logic [31:0] corner2_x,
    input  wire logic [31:0] corner2_y,
    input  wire logic [31:0] corner2_z,
    output logic             valid,
    output logic [11:0]      vertex_index,
    output logic             is_new,
    output logic             table_full,
    output logic             last_of_triangle,
    output logic [31:0]      bound_min_x,
    output logic [31:0]      bound_min_y,
    output logic [31:0]      bound_min_z,
    output logic [31:0]      bound_max_x,
    output logic [31:0]      bound_max_y,
    output logic [31:0]      bound_max_z,
    output logic [31:0]      triangles_seen
);
    typedef enum logic [1:0] {T_IDLE, T_ISSUE, T_WAIT} state_t;

    state_t      state_reg;
    logic        active_reg;
    pos_t        corners_reg [3];
    logic [1:0]  corner_reg;
    logic [31:0] tri_reg;
    pos_t        min_reg;
    pos_t        max_reg;
    logic        valid_reg;
    logic        last_reg;
    lookup_t     out_reg;
    pos_t        cur;
    pos_t        min_next;
    pos_t        max_next;
    logic        tbl_ready;
    logic        tbl_done;
    lookup_t     tbl_res;
    logic        accept;

    assign cur    = corners_reg[corner_reg];
    assign accept = start && !busy;

    vdi_table u_table (
        .clk   (clk),
        .rst_n (rst_n),
        .go    (state_reg == T_ISSUE),
        .pos   (cur),
        .ready (tbl_ready),
        .done  (tbl_done),
        .res   (tbl_res)
    );

    // IEEE bounds: min takes p unless min < p; max takes p when max < p.
    always_comb
    begin
        min_next.x = flt_less(min_reg.x, cur.x) ? min_reg.x : cur.x;
        min_next.y = flt_less(min_reg.y, cur.y) ? min_reg.y : cur.y;
        min_next.z = flt_less(min_reg.z, cur.z) ? min_reg.z : cur.z;
        max_next.x = flt_less(max_reg.x, cur.x) ? cur.x : max_reg.x;
        max_next.y = flt_less(max_reg.y, cur.y) ? cur.y : max_reg.y;
        max_next.z = flt_less(max_reg.z, cur.z) ? cur.z : max_reg.z;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            corners_reg[0] <= '{x: corner0_x, y: corner0_y, z: corner0_z};
            corners_reg[1] <= '{x: corner1_x, y: corner1_y, z: corner1_z};
            corners_reg[2] <= '{x: corner2_x, y: corner2_y, z: corner2_z};
        end
        if (tbl_done)
            out_reg <= tbl_res;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= T_IDLE;
            active_reg <= 1'b0;
            corner_reg <= '0;
            tri_reg    <= '0;
            min_reg    <= '{x: MinReset, y: MinReset, z: MinReset};
            max_reg    <= '{x: MaxReset, y: MaxReset, z: MaxReset};
            valid_reg  <= 1'b0;
            last_reg   <= 1'b0;
        end
        else
        begin
            valid_reg <= 1'b0;
            unique case (state_reg)
                T_IDLE:
                begin
                    if (accept)
                    begin
                        active_reg <= 1'b1;
                        corner_reg <= '0;
                        tri_reg    <= tri_reg + 32'd1;
                        state_reg  <= T_ISSUE;
                    end
                end
                T_ISSUE:
                begin
                    if (tbl_ready)
                        state_reg <= T_WAIT;
                end
                T_WAIT:
                begin
                    if (tbl_done)
                    begin
                        if (tbl_res.fresh)
                        begin
                            min_reg <= min_next;
                            max_reg <= max_next;
                        end
                        valid_reg <= 1'b1;
                        last_reg  <= corner_reg == 2'd2;
                        if (corner_reg == 2'd2)
                        begin
                            active_reg <= 1'b0;
                            state_reg  <= T_IDLE;
                        end
                        else
                        begin
                            corner_reg <= corner_reg + 2'd1;
                            state_reg  <= T_ISSUE;
                        end
                    end
                end
                default:
                    state_reg <= T_IDLE;
            endcase
        end
    end

    // Busy also covers the post-reset clear sweep and the last result cycle.
    assign busy             = active_reg || !tbl_ready || valid_reg;
    assign valid            = valid_reg;
    assign vertex_index     = out_reg.index;
    assign is_new           = out_reg.is_new;
    assign table_full       = out_reg.full;
    assign last_of_triangle = last_reg;
    assign bound_min_x      = min_reg.x;
    assign bound_min_y      = min_reg.y;
    assign bound_min_z      = min_reg.z;
    assign bound_max_x      = max_reg.x;
    assign bound_max_y      = max_reg.y;
    assign bound_max_z      = max_reg.z;
    assign triangles_seen   = tri_reg;

    `CHK_PROP(a_no_accept_busy, clk, rst_n, !(accept && active_reg),
        "request taken while a triangle is in flight")
    `CHK_NEXT(a_last_ends, clk, rst_n, valid_reg && last_reg, !active_reg,
        "triangle still active after last result")
    `CHK_PROP(a_full_new, clk, rst_n, !(valid_reg && out_reg.full) || out_reg.is_new,
        "table full on a known position")
endmodule
`default_nettype wire

>>> rtl/vdi_hash.sv
// Registered position hash: two mixing rounds, one per cycle.
// Depends on vdi_pkg.
`default_nettype none
module vdi_hash
    import vdi_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                go,
    input  wire pos_t                pos,
    output logic                     done,
    output logic [SlotBits-1:0]      slot
);
    logic [31:0] h_reg;
    logic [31:0] h_next;
    logic        st1_reg;
    logic        st2_reg;

    always_comb
    begin
        h_next = st1_reg ? hash_step(h_reg, pos.z) : hash_step(pos.x, pos.y);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st1_reg <= 1'b0;
            st2_reg <= 1'b0;
        end
        else
        begin
            st1_reg <= go;
            st2_reg <= st1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (go || st1_reg)
            h_reg <= h_next;
    end

    assign done = st2_reg;
    assign slot = h_reg[SlotBits-1:0];
endmodule
`default_nettype wire

>>> rtl/vdi_table.sv
// Slot table: key/index memory and valid memory with a probing sequencer.
// Depends on vdi_pkg, vdi_hash, assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"
module vdi_table
    import vdi_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   go,
    input  wire pos_t   pos,
    output logic        ready,
    output logic        done,
    output lookup_t     res
);
    typedef enum logic [2:0] {S_CLEAR, S_IDLE, S_HASH, S_READ, S_CHECK} state_t;

    // entry: {index, z, y, x}
    logic [IdxBits+95:0]  slot_mem [TableSlots];
    logic                 vld_mem [TableSlots];

    state_t               state_reg;
    logic [SlotBits-1:0]  slot_reg;
    logic [ProbeBits-1:0] probe_reg;
    logic [CountBits-1:0] count_reg;
    logic                 done_reg;
    lookup_t              res_reg;
    logic [95:0]          key_rd;
    logic [IdxBits-1:0]   idx_rd;
    logic                 vld_rd;
    logic                 hash_done;
    logic [SlotBits-1:0]  hash_slot;
    logic                 wr_en;
    logic [SlotBits-1:0]  wr_addr;
    logic                 wr_vld;
    logic [SlotBits-1:0]  rd_addr;
    logic                 hit;
    logic                 can_ins;

    vdi_hash u_hash (
        .clk   (clk),
        .rst_n (rst_n),
        .go    (go && state_reg == S_IDLE),
        .pos   (pos),
        .done  (hash_done),
        .slot  (hash_slot)
    );

    assign hit     = vld_rd && key_rd == {pos.z, pos.y, pos.x};
    assign can_ins = !vld_rd && count_reg < CountBits'(MaxVertices);

    always_comb
    begin
        rd_addr = (state_reg == S_HASH) ? hash_slot : slot_reg + SlotBits'(1);
        wr_en   = 1'b0;
        wr_addr = slot_reg;
        wr_vld  = 1'b1;
        if (state_reg == S_CLEAR)
        begin
            wr_en  = 1'b1;
            wr_vld = 1'b0;
        end
        else if (state_reg == S_CHECK && can_ins)
            wr_en = 1'b1;
    end

    always_ff @(posedge clk)
    begin
        {idx_rd, key_rd} <= slot_mem[rd_addr];
        if (wr_en && wr_vld)
            slot_mem[wr_addr] <= {count_reg[IdxBits-1:0], pos.z, pos.y, pos.x};
    end

    always_ff @(posedge clk)
    begin
        vld_rd <= vld_mem[rd_addr];
        if (wr_en)
            vld_mem[wr_addr] <= wr_vld;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            slot_reg  <= '0;
            probe_reg <= '0;
            count_reg <= '0;
            done_reg  <= 1'b0;
            res_reg   <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                S_CLEAR:
                begin
                    slot_reg <= slot_reg + SlotBits'(1);
                    if (slot_reg == SlotBits'(TableSlots - 1))
                        state_reg <= S_IDLE;
                end
                S_IDLE:
                begin
                    if (go)
                        state_reg <= S_HASH;
                end
                S_HASH:
                begin
                    if (hash_done)
                    begin
                        slot_reg  <= hash_slot;
                        probe_reg <= '0;
                        state_reg <= S_CHECK;
                    end
                end
                S_READ:
                    state_reg <= S_CHECK;
                S_CHECK:
                begin
                    if (hit)
                    begin
                        res_reg   <= '{index: idx_rd, is_new: 1'b0, full: 1'b0, fresh: 1'b0};
                        done_reg  <= 1'b1;
                        state_reg <= S_IDLE;
                    end
                    else if (!vld_rd)
                    begin
                        res_reg <= can_ins
                            ? '{index: count_reg[IdxBits-1:0], is_new: 1'b1, full: 1'b0,
                                fresh: 1'b1}
                            : '{index: '0, is_new: 1'b1, full: 1'b1, fresh: 1'b0};
                        if (can_ins)
                            count_reg <= count_reg + CountBits'(1);
                        done_reg  <= 1'b1;
                        state_reg <= S_IDLE;
                    end
                    else if (probe_reg == ProbeBits'(TableSlots - 1))
                    begin
                        res_reg   <= '{index: '0, is_new: 1'b1, full: 1'b1, fresh: 1'b0};
                        done_reg  <= 1'b1;
                        state_reg <= S_IDLE;
                    end
                    else
                    begin
                        slot_reg  <= slot_reg + SlotBits'(1);
                        probe_reg <= probe_reg + ProbeBits'(1);
                    end
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    assign ready = state_reg == S_IDLE;
    assign done  = done_reg;
    assign res   = res_reg;

    `CHK_PROP(a_count_cap, clk, rst_n, count_reg <= CountBits'(MaxVertices),
        "distinct count past capacity")
    `CHK_NEXT(a_insert_done, clk, rst_n, state_reg == S_CHECK && can_ins, done_reg,
        "insert without result")
    `CHK_PROP(a_done_idle, clk, rst_n, !done_reg || state_reg == S_IDLE,
        "result while still probing")
endmodule
`default_nettype wire

>>> verif/vdi_checker.sv
`timescale 1ns / 100ps
// Checker for the vertex dedup indexer: watches accepted triangle requests and
// result strobes, predicts the welded indices and bounds, compares.
// Depends on vdi_pkg.
module vdi_checker
    import vdi_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic        busy,
    input  logic [31:0] c0x, c0y, c0z, c1x, c1y, c1z, c2x, c2y, c2z,
    input  logic        valid,
    input  logic [11:0] vertex_index,
    input  logic        is_new,
    input  logic        table_full,
    input  logic        last_of_triangle,
    input  logic [31:0] bound_min_x, bound_min_y, bound_min_z,
    input  logic [31:0] bound_max_x, bound_max_y, bound_max_z,
    input  logic [31:0] triangles_seen,
    output int          errors,
    output int          pending
);
    typedef struct packed {
        logic [11:0] index;
        logic        fresh;
        logic        full;
        logic        last;
        logic [31:0] mnx, mny, mnz, mxx, mxy, mxz;
        logic [31:0] tri_cnt;
    } weld_t;

    weld_t       weld_q[$];
    // model of the slot store: key -> index
    logic [11:0] known_pos[logic [95:0]];
    int          distinct;
    logic [31:0] tri_total;
    logic [31:0] lo[3];
    logic [31:0] hi[3];

    function automatic bit nan_bits(logic [31:0] a);
        return a[30:23] == 8'hFF && a[22:0] != 23'd0;
    endfunction

    // IEEE a < b on raw bits
    function automatic bit below(logic [31:0] a, logic [31:0] b);
        logic [31:0] ka, kb;
        ka = a[31] ? ~a : (a | 32'h80000000);
        kb = b[31] ? ~b : (b | 32'h80000000);
        if (nan_bits(a) || nan_bits(b)) return 1'b0;
        if (a[30:0] == 31'd0 && b[30:0] == 31'd0) return 1'b0;
        return ka < kb;
    endfunction

    task automatic weld(logic [31:0] x, logic [31:0] y, logic [31:0] z, bit last);
        weld_t       w;
        logic [31:0] p[3];
        p[0] = x; p[1] = y; p[2] = z;
        w.last = last;
        w.full = 1'b0;
        if (known_pos.exists({x, y, z})) begin
            w.index = known_pos[{x, y, z}];
            w.fresh = 1'b0;
        end else if (distinct >= MaxVertices) begin
            // no slot left: flagged, not stored, bounds untouched
            w.index = '0;
            w.fresh = 1'b1;
            w.full = 1'b1;
        end else begin
            w.index = distinct[11:0];
            w.fresh = 1'b1;
            known_pos[{x, y, z}] = distinct[11:0];
            distinct++;
            for (int a = 0; a < 3; a++) begin
                if (!below(lo[a], p[a])) lo[a] = p[a];
                if (below(hi[a], p[a])) hi[a] = p[a];
            end
        end
        w.mnx = lo[0]; w.mny = lo[1]; w.mnz = lo[2];
        w.mxx = hi[0]; w.mxy = hi[1]; w.mxz = hi[2];
        w.tri_cnt = tri_total;
        weld_q = {weld_q, w};
    endtask

    task automatic cmp(string f, logic [31:0] e, logic [31:0] a);
        if (e !== a) begin
            $error("%s: expected %h, got %h", f, e, a);
            errors++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        weld_t w;
        if (!rst_n)
        begin
            weld_q.delete();
            known_pos.delete();
            distinct = 0;
            tri_total = 0;
            for (int a = 0; a < 3; a++)
            begin
                lo[a] = MinReset;
                hi[a] = MaxReset;
            end
            errors = 0;
            pending = 0;
        end
        else
        begin
            if (valid)
            begin
                if (weld_q.size() == 0)
                begin
                    $error("result strobe with no request outstanding");
                    errors++;
                end
                else
                begin
                    w = weld_q.pop_front();
                    cmp("vertex_index", 32'(w.index), 32'(vertex_index));
                    cmp("is_new", 32'(w.fresh), 32'(is_new));
                    cmp("table_full", 32'(w.full), 32'(table_full));
                    cmp("last_of_triangle", 32'(w.last), 32'(last_of_triangle));
                    cmp("bound_min_x", w.mnx, bound_min_x);
                    cmp("bound_min_y", w.mny, bound_min_y);
                    cmp("bound_min_z", w.mnz, bound_min_z);
                    cmp("bound_max_x", w.mxx, bound_max_x);
                    cmp("bound_max_y", w.mxy, bound_max_y);
                    cmp("bound_max_z", w.mxz, bound_max_z);
                    cmp("triangles_seen", w.tri_cnt, triangles_seen);
                end
            end
            if (start && !busy)
            begin
                tri_total++;
                weld(c0x, c0y, c0z, 1'b0);
                weld(c1x, c1y, c1z, 1'b0);
                weld(c2x, c2y, c2z, 1'b1);
            end
            pending = weld_q.size();
        end
    end
endmodule

>>> verif/tb_vertex_dedup_indexer.sv
`timescale 1ns / 100ps
// Testbench top for the vertex dedup indexer: drives triangle requests with
// bursty gaps; vdi_checker does prediction and comparison. Depends on vdi_pkg.
module tb_vertex_dedup_indexer;
    import vdi_pkg::*;

    logic        clk = 0;
    logic        rst_n = 0;
    logic        start = 0;
    logic [31:0] crd[9];
    logic        busy, valid, is_new, table_full, last_of_triangle;
    logic [11:0] vertex_index;
    logic [31:0] bmnx, bmny, bmnz, bmxx, bmxy, bmxz, tri_seen;
    int          errors, pending;
    // pool of positions already sent, so repeats hit the table
    logic [95:0] seen_pos[$];
    int          burst_left;

    initial for (int i = 0; i < 9; i++) crd[i] = 0;

    always #5 clk = ~clk;

    vertex_dedup_indexer dut (
        .clk, .rst_n, .start, .busy,
        .corner0_x(crd[0]), .corner0_y(crd[1]), .corner0_z(crd[2]),
        .corner1_x(crd[3]), .corner1_y(crd[4]), .corner1_z(crd[5]),
        .corner2_x(crd[6]), .corner2_y(crd[7]), .corner2_z(crd[8]),
        .valid, .vertex_index, .is_new, .table_full, .last_of_triangle,
        .bound_min_x(bmnx), .bound_min_y(bmny), .bound_min_z(bmnz),
        .bound_max_x(bmxx), .bound_max_y(bmxy), .bound_max_z(bmxz),
        .triangles_seen(tri_seen)
    );

    vdi_checker chk (
        .clk, .rst_n, .start, .busy,
        .c0x(crd[0]), .c0y(crd[1]), .c0z(crd[2]),
        .c1x(crd[3]), .c1y(crd[4]), .c1z(crd[5]),
        .c2x(crd[6]), .c2y(crd[7]), .c2z(crd[8]),
        .valid, .vertex_index, .is_new, .table_full, .last_of_triangle,
        .bound_min_x(bmnx), .bound_min_y(bmny), .bound_min_z(bmnz),
        .bound_max_x(bmxx), .bound_max_y(bmxy), .bound_max_z(bmxz),
        .triangles_seen(tri_seen), .errors, .pending
    );

    // Present one triangle at the falling edge, hold start until taken.
    // Start drops only for a gap between bursts, so requests inside a burst
    // follow back to back.
    task automatic send_triangle(logic [95:0] c0, logic [95:0] c1, logic [95:0] c2);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 6);
            gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 20);
            if (gap > 0)
            begin
                start <= 0;
                repeat (gap) @(negedge clk);
            end
        end
        burst_left--;
        {crd[0], crd[1], crd[2]} = c0;
        {crd[3], crd[4], crd[5]} = c1;
        {crd[6], crd[7], crd[8]} = c2;
        start <= 1;
        @(posedge clk);
        while (busy) @(posedge clk);
        seen_pos = {seen_pos, c0, c1, c2};
        @(negedge clk);
    endtask

    // Random coordinate: half raw bits, the rest zeros, NaNs, infinities, bounds, small integers.
    function automatic logic [31:0] rand_coord();
        case ($urandom_range(0, 9))
            0: return {$urandom_range(0, 1) == 1, 31'd0};
            1: return {$urandom_range(0, 1) == 1, 8'hFF, 23'($urandom_range(1, 8388607))};
            2: return {$urandom_range(0, 1) == 1, 8'hFF, 23'd0};
            3: return $urandom_range(0, 1) ? MinReset : MaxReset;
            4: return 32'($urandom_range(0, 7));
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [95:0] pick_corner();
        if (seen_pos.size() > 0 && $urandom_range(0, 2) == 0)
            return seen_pos[$urandom_range(0, seen_pos.size() - 1)];
        return {rand_coord(), rand_coord(), rand_coord()};
    endfunction

    initial
    begin
        burst_left = 0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1;

        // Directed: all-zero and all-ones extremes, repeated corners in one
        // triangle, signed zeros as distinct keys, NaN minimum replacement,
        // infinities and the reset bound values themselves.
        send_triangle('0, '1, '0);
        send_triangle({3{32'h00000000}}, {3{32'h80000000}}, {3{32'h80000000}});
        send_triangle({3{32'h7FC00000}}, {3{32'h7FC00001}}, {3{32'hFFC00000}});
        send_triangle({3{32'h7F800000}}, {3{32'hFF800000}}, {3{MinReset}});
        send_triangle({3{MaxReset}}, {3{32'h3F800000}}, {3{32'hBF800000}});
        send_triangle({32'h3F800000, 32'h0, 32'h0}, {32'h0, 32'h3F800000, 32'h0},
                      {32'h0, 32'h0, 32'h3F800000});
        send_triangle({32'h55555555, 32'hAAAAAAAA, 32'h55555555},
                      {32'hAAAAAAAA, 32'h55555555, 32'hAAAAAAAA}, '1);

        // Random: mesh-like, many shared corners.
        for (int t = 0; t < 143; t++)
            send_triangle(pick_corner(), pick_corner(), pick_corner());
        start <= 0;

        while (pending != 0) @(posedge clk);
        repeat (40) @(posedge clk);
        if (errors == 0)
            $display("tb_vertex_dedup_indexer passed");
        else
            $display("tb_vertex_dedup_indexer failed");
        $finish;
    end

    // Watchdog: covers the clearing sweep plus ~150 triangles.
    initial
    begin
        #1_000_000;
        $display("tb_vertex_dedup_indexer failed");
        $finish;
    end
endmodule
